// ----- rtl/core/idq_pkg.sv -----
// Package for the indexed deque store: field widths, command codes and
// status codes shared by the interfaces and the core. No dependencies.
package idq_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 9;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 9;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK = 3'd0,
    CMD_POP_BACK  = 3'd1,
    CMD_POP_FRONT = 3'd2,
    CMD_READ_AT   = 3'd3,
    CMD_WRITE_AT  = 3'd4,
    CMD_RESIZE    = 3'd5,
    CMD_CLEAR     = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

// ----- rtl/core/idq_if.sv -----
// Valid/ready channel interfaces for the indexed deque store: command words
// in, result words out. Depends on idq_pkg.
interface idq_in_if import idq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

interface idq_out_if import idq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  value_out;
  logic [LEN_W-1:0]  length;
  logic [STAT_W-1:0] status;

  modport source (output valid, value_out, length, status, input ready);
  modport sink (input valid, value_out, length, status, output ready);
endinterface

// ----- rtl/core/idq_ram.sv -----
// Generic single-port RAM with registered read data, used for the element store.
// No dependencies.
module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds until the next read, so a stalled result stays intact.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/core/indexed_deque_store_core.sv -----
// Top level of the indexed deque store: ring buffer with front pointer and count.
// Depends on idq_pkg, idq_in_if, idq_out_if and idq_ram.
//
// Channel    Dir  Word
// request    in   command, position, value
// response   out  value_out, length, status
//
// One command is accepted per cycle while request.ready is high; its result passes
// the result stage and then the output register. Each command makes at most one
// access to the single-port element RAM, which sets the rate of one word per cycle.
// Reset clears the front pointer, the count and the pipeline; memory keeps its data.
// A stalled response holds the result stage and the RAM read data, and
// request.ready falls once both stages are occupied.
module indexed_deque_store_core import idq_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  idq_in_if.sink    request,
  idq_out_if.source response
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > POS_W) ? CW : POS_W;
  localparam int SW = PW + 1;
  localparam int XW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
  localparam logic [CW-1:0] CAP_C      = CW'(CAPACITY);
  localparam logic [EW-1:0] CAP_E      = EW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S      = SW'(CAPACITY);
  localparam logic [PW-1:0] CAP_P_LAST = PW'(CAPACITY - 1);

  // Architectural state
  logic [PW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  // Result stage (RAM read data lines up with it)
  logic             s1_valid;
  logic             s1_rd;
  logic [LEN_W-1:0] s1_len;
  status_t          s1_status;

  // Output register
  logic              res_valid;
  logic [VAL_W-1:0]  res_value;
  logic [LEN_W-1:0]  res_len;
  status_t           res_status;

  logic acc, s1_adv;
  logic mem_en, mem_we, rd_hit;
  status_t st;
  logic [PW-1:0] off, slot, front_inc;
  logic [SW-1:0] sum;
  logic [CW-1:0] cnt_m1;
  logic [EW-1:0] pos_e, cnt_e;
  logic [XW-1:0] val_x, rd_x;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  assign s1_adv        = !res_valid || response.ready;
  assign request.ready = !s1_valid || s1_adv;
  assign acc           = request.valid && request.ready;

  assign cnt_m1    = count - 1'b1;
  assign pos_e     = EW'(request.position);
  assign cnt_e     = EW'(count);
  assign front_inc = (front == CAP_P_LAST) ? '0 : front + 1'b1;

  // Logical position to physical slot; the sum stays below twice the capacity.
  assign sum  = {1'b0, front} + {1'b0, off};
  assign slot = (sum >= CAP_S) ? PW'(sum - CAP_S) : sum[PW-1:0];

  always_comb begin
    front_next = front;
    count_next = count;
    st         = ST_OK;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    rd_hit     = 1'b0;
    off        = '0;
    case (request.command) inside
      CMD_PUSH_BACK: begin
        off = count[PW-1:0];
        if (count == CAP_C) begin
          st = ST_FULL;
        end else begin
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        off = cnt_m1[PW-1:0];
        if (count == '0) begin
          st = ST_EMPTY;
        end else begin
          mem_en     = 1'b1;
          rd_hit     = 1'b1;
          count_next = cnt_m1;
        end
      end
      CMD_POP_FRONT: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else begin
          mem_en     = 1'b1;
          rd_hit     = 1'b1;
          count_next = cnt_m1;
          front_next = front_inc;
        end
      end
      CMD_READ_AT, CMD_WRITE_AT: begin
        off = pos_e[PW-1:0];
        if (pos_e >= cnt_e) begin
          st = ST_RANGE;
        end else begin
          mem_en = 1'b1;
          mem_we = (request.command == CMD_WRITE_AT);
          rd_hit = (request.command == CMD_READ_AT);
        end
      end
      CMD_RESIZE: begin
        if (pos_e > CAP_E) begin
          st = ST_RANGE;
        end else begin
          count_next = pos_e[CW-1:0];
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
        front_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign val_x = XW'(request.value);
  assign wdata = val_x[DATA_WIDTH-1:0];
  assign rd_x  = XW'(rdata);

  idq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .en   (acc && mem_en),
    .we   (mem_we),
    .addr (slot),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (acc) begin
        front <= front_next;
        count <= count_next;
      end
      // An empty result stage takes a word even while the output register is stalled.
      if (s1_adv || !s1_valid) begin
        s1_valid <= acc;
      end
      if (s1_adv) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_rd     <= rd_hit;
      s1_len    <= LEN_W'(count_next);
      s1_status <= st;
    end
    if (s1_adv && s1_valid) begin
      res_value  <= s1_rd ? rd_x[VAL_W-1:0] : '0;
      res_len    <= s1_len;
      res_status <= s1_status;
    end
  end

  assign response.valid     = res_valid;
  assign response.value_out = res_value;
  assign response.length    = res_len;
  assign response.status    = res_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("element count exceeds capacity");

  a_front_bound: assert property (@(posedge clk) disable iff (rst) front <= CAP_P_LAST)
    else $error("front pointer beyond last slot");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst) acc |=> s1_valid)
    else $error("accepted word lost before result stage");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != ST_OK) |-> (res_value == '0))
    else $error("error result carries data");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_FULL) |-> (res_len == LEN_W'(CAPACITY)))
    else $error("full status with length below capacity");

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the indexed deque store core: directed and random command words are
// driven in, and each result word is checked against a behavioural deque in the bench.
// Depends on idq_pkg, idq_in_if, idq_out_if and indexed_deque_store_core.
module tb_top import idq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int QUIET_TAIL = 200;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } deque_cmd_t;

  typedef struct {
    logic [VAL_W-1:0] value_out;
    logic [LEN_W-1:0] length;
    status_t          status;
    bit               value_known;
  } deque_result_t;

  logic clk;
  logic rst;

  idq_in_if  request ();
  idq_out_if response ();

  indexed_deque_store_core #(
    .CAPACITY   (DEPTH),
    .DATA_WIDTH (VAL_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response)
  );

  // Behavioural deque, advanced once per accepted command word.
  logic [VAL_W-1:0] deque_mem [DEPTH];
  bit               deque_known [DEPTH];
  int unsigned      deque_front = 0;
  int unsigned      deque_count = 0;
  deque_result_t    pending_results [$];

  // Shadow of the stimulus plan, used only to steer the generator.
  bit          plan_written [DEPTH];
  int unsigned plan_front = 0;
  int unsigned plan_count = 0;
  deque_cmd_t  cmd_backlog [$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatch_count = 0;

  int unsigned send_cycle = 0;
  int unsigned send_idle_pct = 15;
  int unsigned send_gap = 0;
  int unsigned recv_cycle = 0;
  int unsigned recv_idle_pct = 15;
  int unsigned recv_stall = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned ring_slot(int unsigned front, int unsigned p);
    return (front + p) % DEPTH;
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  task automatic apply_deque_cmd(deque_cmd_t c);
    deque_result_t r;
    int unsigned s;
    r.value_out = '0;
    r.status = ST_OK;
    r.value_known = 1'b1;
    case (c.command)
      CMD_PUSH_BACK: begin
        if (deque_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          s = ring_slot(deque_front, deque_count);
          deque_mem[s] = c.value;
          deque_known[s] = 1'b1;
          deque_count++;
        end
      end
      CMD_POP_BACK: begin
        if (deque_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          deque_count--;
          s = ring_slot(deque_front, deque_count);
          r.value_out = deque_mem[s];
          r.value_known = deque_known[s];
        end
      end
      CMD_POP_FRONT: begin
        if (deque_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value_out = deque_mem[deque_front];
          r.value_known = deque_known[deque_front];
          deque_front = ring_slot(deque_front, 1);
          deque_count--;
        end
      end
      CMD_READ_AT: begin
        if (c.position >= deque_count) begin
          r.status = ST_RANGE;
        end else begin
          s = ring_slot(deque_front, c.position);
          r.value_out = deque_mem[s];
          r.value_known = deque_known[s];
        end
      end
      CMD_WRITE_AT: begin
        if (c.position >= deque_count) begin
          r.status = ST_RANGE;
        end else begin
          s = ring_slot(deque_front, c.position);
          deque_mem[s] = c.value;
          deque_known[s] = 1'b1;
        end
      end
      CMD_RESIZE: begin
        if (c.position > DEPTH) begin
          r.status = ST_RANGE;
        end else begin
          // Entries uncovered by growing hold whatever the memory had, so they go unchecked.
          for (int unsigned i = deque_count; i < c.position; i++) begin
            deque_known[ring_slot(deque_front, i)] = 1'b0;
          end
          deque_count = c.position;
        end
      end
      CMD_CLEAR: begin
        deque_count = 0;
        deque_front = 0;
      end
      default: ;
    endcase
    r.length = LEN_W'(deque_count);
    pending_results.push_back(r);
  endtask

  task automatic compare_result();
    deque_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result word with none expected: value_out %h length %0d status %0d",
               $time, response.value_out, response.length, response.status);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      if (want.value_known && response.value_out !== want.value_out) begin
        $display("%0t: value_out expected %h, actual %h", $time, want.value_out,
                 response.value_out);
        mismatch_count++;
      end
      if (response.length !== want.length) begin
        $display("%0t: length expected %0d, actual %0d", $time, want.length,
                 response.length);
        mismatch_count++;
      end
      if (response.status !== want.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, want.status,
                 response.status);
        mismatch_count++;
      end
    end
  endtask

  task automatic plan_cmd(logic [CMD_W-1:0] command, int unsigned position,
                          logic [VAL_W-1:0] value);
    deque_cmd_t c;
    c.command = command;
    c.position = POS_W'(position);
    c.value = value;
    case (command)
      CMD_PUSH_BACK: begin
        if (plan_count < DEPTH) begin
          plan_written[ring_slot(plan_front, plan_count)] = 1'b1;
          plan_count++;
        end
      end
      CMD_POP_BACK: if (plan_count > 0) plan_count--;
      CMD_POP_FRONT: begin
        if (plan_count > 0) begin
          plan_front = ring_slot(plan_front, 1);
          plan_count--;
        end
      end
      CMD_WRITE_AT: begin
        if (position < plan_count) plan_written[ring_slot(plan_front, position)] = 1'b1;
      end
      CMD_RESIZE: if (position <= DEPTH) plan_count = position;
      CMD_CLEAR: begin
        plan_count = 0;
        plan_front = 0;
      end
      default: ;
    endcase
    cmd_backlog.push_back(c);
    queued_total++;
  endtask

  function automatic bit plan_readable(int unsigned p);
    return plan_written[ring_slot(plan_front, p)];
  endfunction

  // Mode 0 leans towards filling, mode 1 towards draining, anything else is balanced.
  task automatic plan_random(int unsigned mode);
    int unsigned roll;
    int unsigned pos;
    int unsigned push_w;
    int unsigned pop_w;
    logic [CMD_W-1:0] cmd;
    case (mode)
      0: begin push_w = 60; pop_w = 10; end
      1: begin push_w = 15; pop_w = 50; end
      default: begin push_w = 30; pop_w = 25; end
    endcase
    pos = $urandom_range(511);
    roll = $urandom_range(99);
    if (roll < push_w) begin
      cmd = CMD_PUSH_BACK;
    end else if (roll < push_w + pop_w) begin
      cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 40) cmd = CMD_READ_AT;
      else if (roll < 75) cmd = CMD_WRITE_AT;
      else if (roll < 93) cmd = CMD_RESIZE;
      else if (roll < 95) cmd = CMD_CLEAR;
      else cmd = CMD_UNUSED;
    end
    roll = $urandom_range(99);
    if (cmd == CMD_READ_AT || cmd == CMD_WRITE_AT) begin
      if (plan_count > 0 && roll >= 30) pos = $urandom_range(plan_count - 1);
      else if (plan_count > 0 && roll >= 20) pos = plan_count - 1;
      else if (roll >= 10) pos = plan_count;
    end else if (cmd == CMD_RESIZE) begin
      if (roll < 50) pos = $urandom_range(plan_count);
      else if (roll < 80) pos = $urandom_range(DEPTH, plan_count);
      else if (roll < 90) pos = DEPTH;
    end
    // Never ask for an entry that has not been written since the start of the run.
    if ((cmd == CMD_POP_BACK && plan_count > 0 && !plan_readable(plan_count - 1)) ||
        (cmd == CMD_POP_FRONT && plan_count > 0 && !plan_readable(0)) ||
        (cmd == CMD_READ_AT && pos < plan_count && !plan_readable(pos))) begin
      cmd = CMD_PUSH_BACK;
    end
    plan_cmd(cmd, pos, $urandom());
  endtask

  always @(posedge clk) begin
    deque_cmd_t word;
    if (rst) begin
      request.valid <= 1'b0;
    end else begin
      if (request.valid && request.ready) begin
        word.command = request.command;
        word.position = request.position;
        word.value = request.value;
        apply_deque_cmd(word);
        accepted_total++;
      end
      send_cycle++;
      if (send_cycle % 64 == 0) send_idle_pct = pick_idle_pct();
      if (!request.valid || request.ready) begin
        if (send_gap == 0 && cmd_backlog.size() > QUIET_TAIL &&
            $urandom_range(99) < send_idle_pct) begin
          send_gap = $urandom_range(4, 1);
        end
        if (send_gap > 0) begin
          send_gap--;
          request.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          word = cmd_backlog.pop_front();
          request.valid <= 1'b1;
          request.command <= word.command;
          request.position <= word.position;
          request.value <= word.value;
        end else begin
          request.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      response.ready <= 1'b0;
    end else begin
      if (response.valid && response.ready) compare_result();
      recv_cycle++;
      if (recv_cycle % 64 == 32) recv_idle_pct = pick_idle_pct();
      if (recv_stall == 0 && cmd_backlog.size() > QUIET_TAIL &&
          $urandom_range(99) < recv_idle_pct) begin
        recv_stall = $urandom_range(4, 1);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        response.ready <= 1'b0;
      end else begin
        response.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned mode;
    rst = 1'b1;
    request.valid = 1'b0;
    request.command = '0;
    request.position = '0;
    request.value = '0;
    response.ready = 1'b0;

    // Empty store, out-of-range positions and resizes, unused code, then a filled store.
    plan_cmd(CMD_POP_BACK, 0, 32'h0);
    plan_cmd(CMD_POP_FRONT, 0, 32'h0);
    plan_cmd(CMD_READ_AT, 0, 32'h0);
    plan_cmd(CMD_WRITE_AT, 0, 32'hFFFF_FFFF);
    plan_cmd(CMD_RESIZE, DEPTH + 1, 32'h0);
    plan_cmd(CMD_RESIZE, 511, 32'h0);
    plan_cmd(CMD_UNUSED, 511, 32'hFFFF_FFFF);
    plan_cmd(CMD_PUSH_BACK, 0, 32'h0);
    plan_cmd(CMD_PUSH_BACK, 511, 32'hFFFF_FFFF);
    plan_cmd(CMD_PUSH_BACK, 0, 32'h8000_0001);
    plan_cmd(CMD_READ_AT, 0, 32'h0);
    plan_cmd(CMD_READ_AT, 2, 32'h0);
    plan_cmd(CMD_READ_AT, 3, 32'h0);
    plan_cmd(CMD_WRITE_AT, 1, 32'h5A5A_5A5A);
    plan_cmd(CMD_READ_AT, 1, 32'h0);
    plan_cmd(CMD_POP_FRONT, 0, 32'h0);
    plan_cmd(CMD_POP_BACK, 0, 32'h0);
    plan_cmd(CMD_RESIZE, 0, 32'h0);
    plan_cmd(CMD_PUSH_BACK, 0, $urandom());
    plan_cmd(CMD_RESIZE, DEPTH, 32'h0);
    plan_cmd(CMD_PUSH_BACK, 0, $urandom());
    plan_cmd(CMD_RESIZE, 1, 32'h0);
    plan_cmd(CMD_READ_AT, 0, 32'h0);
    plan_cmd(CMD_CLEAR, 0, 32'h0);
    plan_cmd(CMD_POP_FRONT, 0, 32'h0);

    for (int seg = 0; seg < 17; seg++) begin
      mode = $urandom_range(2);
      repeat (100) plan_random(mode);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_total < queued_total || pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/idq_pkg.sv
rtl/core/idq_if.sv
rtl/core/idq_ram.sv
rtl/core/indexed_deque_store_core.sv
tb/tb_top.sv
